### rtl/core/smpd_pkg.sv
package smpd_pkg;

  // table depth and derived widths
  localparam int SLOTS      = 10;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MISS_LIMIT = 9;
  localparam int MISS_W     = 4;

  // field widths
  localparam int SMP_W   = 12;
  localparam int GAP_W   = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 56;
  localparam int CFG_A_W = 2;

  // register reset values
  localparam logic [SMP_W-1:0] THR_RESET  = 12'd2200;
  localparam logic [SMP_W-1:0] STOL_RESET = 12'd6;
  localparam logic [GAP_W-1:0] GTOL_RESET = 16'd6;
  localparam logic [SMP_W-1:0] SMP_MAX    = 12'hFFF;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_SLOPE_TOL = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_GAP_TOL   = 2'd2;

  // item kinds
  localparam logic ACT_SAMPLE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic sum_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_sum;
    logic sum_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/smpd_ctrl.sv
module smpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  smpd_pkg::dp_status_t status,
  output smpd_pkg::dp_cmd_t    cmd
);
  import smpd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.need_sum ? ST_SUM : ST_OUT;
      end
      ST_SUM: begin
        if (status.sum_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free) else $error("result loaded into a busy slot");
  a_sum_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && status.need_sum) |=> (state_r == ST_SUM)) else $error("gap sum skipped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one command at once");

endmodule

### rtl/core/smpd_dp.sv
module smpd_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  smpd_pkg::dp_cmd_t                cmd,
  output smpd_pkg::dp_status_t             status,
  input  logic [smpd_pkg::IN_W-1:0]        in_tdata,
  input  logic                             in_tuser,
  input  logic                             cfg_valid,
  input  logic [smpd_pkg::CFG_A_W-1:0]     cfg_index,
  input  logic [smpd_pkg::GAP_W-1:0]       cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [smpd_pkg::OUT_W-1:0]       out_tdata,
  output logic                             out_tuser
);
  import smpd_pkg::*;

  // configuration
  logic [SMP_W-1:0] thr_r, thr_nxt;
  logic [SMP_W-1:0] stol_r, stol_nxt;
  logic [GAP_W-1:0] gtol_r, gtol_nxt;

  // captured item
  logic             act_r;
  logic [SMP_W-1:0] smp_r;

  // detector state
  logic [SMP_W-1:0]  prev_r, prev_nxt;
  logic [GAP_W-1:0]  tick_r, tick_nxt;
  logic [SMP_W-1:0]  slope_tab_r [SLOTS];
  logic [SMP_W-1:0]  slope_tab_nxt [SLOTS];
  logic [GAP_W-1:0]  gap_tab_r [SLOTS];
  logic [GAP_W-1:0]  gap_tab_nxt [SLOTS];
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [SMP_W-1:0]  pslope_r, pslope_nxt;
  logic [MISS_W-1:0] miss_r, miss_nxt;
  logic [GAP_W-1:0]  period_r, period_nxt;
  logic [SMP_W-1:0]  level_r, level_nxt;
  logic [SMP_W-1:0]  max_r, max_nxt;
  logic [SMP_W-1:0]  min_r, min_nxt;
  logic              seen_r, seen_nxt;
  logic              upd_r, upd_nxt;

  // gap sum unit
  logic [IDX_W-1:0] k_r;
  logic [GAP_W-1:0] sum_r;
  logic [IDX_W-1:0] hold_idx_r;
  logic [GAP_W-1:0] hold_gap_r;
  logic [SMP_W-1:0] hold_slope_r;
  logic [GAP_W-1:0] sum_add;

  // output slot
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic             out_user_r;

  // evaluation terms
  logic              crossing;
  logic [SMP_W-1:0]  slope;
  logic [SMP_W-1:0]  slope_diff;
  logic [SMP_W-1:0]  slope0_diff;
  logic [GAP_W-1:0]  gap_diff;
  logic              slope_hit;
  logic              repeat_hit;
  logic              idx_zero;
  logic [CNT_W-1:0]  slot_inc;
  logic              table_full;
  logic [MISS_W-1:0] miss_inc;
  logic              miss_over;
  logic [SMP_W-1:0]  level_dec;

  // crossing and match tests
  always_comb begin
    crossing    = (prev_r < thr_r) && (smp_r >= thr_r);
    slope       = smp_r - prev_r;
    slope_diff  = (slope > pslope_r) ? (slope - pslope_r) : (pslope_r - slope);
    slope0_diff = (slope > slope_tab_r[0]) ? (slope - slope_tab_r[0])
                                           : (slope_tab_r[0] - slope);
    gap_diff    = (tick_r > gap_tab_r[0]) ? (tick_r - gap_tab_r[0])
                                          : (gap_tab_r[0] - tick_r);
    slope_hit   = slope_diff < stol_r;
    idx_zero    = (slot_r == '0);
    repeat_hit  = !idx_zero && (gap_diff < gtol_r) && (slope0_diff < stol_r);
    slot_inc    = {1'b0, slot_r} + CNT_W'(1);
    table_full  = slot_inc >= CNT_W'(SLOTS);
    miss_inc    = miss_r + MISS_W'(1);
    miss_over   = miss_inc > MISS_W'(MISS_LIMIT);
    level_dec   = (level_r == '0) ? '0 : (level_r - SMP_W'(1));
    sum_add     = sum_r + gap_tab_r[k_r];
  end

  // status to the controller
  always_comb begin
    status.need_sum = (act_r == ACT_SAMPLE) && crossing && slope_hit && repeat_hit;
    status.sum_last = ({1'b0, k_r} + CNT_W'(1)) == {1'b0, hold_idx_r};
    status.out_free = !out_valid_r || out_tready;
  end

  // next state of the detector and configuration
  always_comb begin
    thr_nxt       = thr_r;
    stol_nxt      = stol_r;
    gtol_nxt      = gtol_r;
    prev_nxt      = prev_r;
    tick_nxt      = tick_r;
    slope_tab_nxt = slope_tab_r;
    gap_tab_nxt   = gap_tab_r;
    slot_nxt      = slot_r;
    pslope_nxt    = pslope_r;
    miss_nxt      = miss_r;
    period_nxt    = period_r;
    level_nxt     = level_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    seen_nxt      = seen_r;
    upd_nxt       = upd_r;

    // register writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_nxt  = cfg_data[SMP_W-1:0];
        CFG_SLOPE_TOL: stol_nxt = cfg_data[SMP_W-1:0];
        CFG_GAP_TOL:   gtol_nxt = cfg_data;
        default:       thr_nxt  = thr_r;
      endcase
    end

    // one item: sample or level read
    if (cmd.eval) begin
      upd_nxt = 1'b0;
      if (act_r == ACT_SAMPLE) begin
        prev_nxt  = smp_r;
        seen_nxt  = 1'b1;
        if (smp_r > max_r) max_nxt = smp_r;
        if (smp_r < min_r) min_nxt = smp_r;
        level_nxt = (smp_r > level_r) ? smp_r : level_dec;
        tick_nxt  = tick_r + GAP_W'(1);
        if (crossing) begin
          if (slope_hit) begin
            slope_tab_nxt[slot_r] = slope;
            gap_tab_nxt[slot_r]   = tick_r;
            tick_nxt              = GAP_W'(1);
            if (idx_zero || repeat_hit) begin
              miss_nxt = '0;
              slot_nxt = IDX_W'(1);
            end else if (table_full) begin
              slot_nxt   = '0;
              miss_nxt   = '0;
              pslope_nxt = '0;
            end else begin
              slot_nxt = slot_inc[IDX_W-1:0];
            end
          end else if (slope > pslope_r) begin
            pslope_nxt = slope;
            tick_nxt   = GAP_W'(1);
            miss_nxt   = '0;
            slot_nxt   = '0;
          end else if (miss_over) begin
            slot_nxt   = '0;
            miss_nxt   = '0;
            pslope_nxt = '0;
          end else begin
            miss_nxt = miss_inc;
          end
        end
      end else begin
        level_nxt = level_dec;
      end
    end

    // last gap added: new period, matched crossing becomes the first entry
    if (cmd.sum_step && status.sum_last) begin
      period_nxt       = sum_add;
      upd_nxt          = 1'b1;
      gap_tab_nxt[0]   = hold_gap_r;
      slope_tab_nxt[0] = hold_slope_r;
    end
  end

  // output slot handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and detector state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      stol_r      <= STOL_RESET;
      gtol_r      <= GTOL_RESET;
      prev_r      <= '0;
      tick_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slope_tab_r[i] <= '0;
        gap_tab_r[i]   <= '0;
      end
      slot_r      <= '0;
      pslope_r    <= '0;
      miss_r      <= '0;
      period_r    <= '0;
      level_r     <= '0;
      max_r       <= '0;
      min_r       <= SMP_MAX;
      seen_r      <= 1'b0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      stol_r      <= stol_nxt;
      gtol_r      <= gtol_nxt;
      prev_r      <= prev_nxt;
      tick_r      <= tick_nxt;
      slope_tab_r <= slope_tab_nxt;
      gap_tab_r   <= gap_tab_nxt;
      slot_r      <= slot_nxt;
      pslope_r    <= pslope_nxt;
      miss_r      <= miss_nxt;
      period_r    <= period_nxt;
      level_r     <= level_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      seen_r      <= seen_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture, gap sum and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_tuser;
      smp_r <= in_tdata[SMP_W-1:0];
    end
    if (cmd.eval) begin
      k_r          <= '0;
      sum_r        <= '0;
      hold_idx_r   <= slot_r;
      hold_gap_r   <= tick_r;
      hold_slope_r <= slope;
    end else if (cmd.sum_step) begin
      k_r   <= k_r + IDX_W'(1);
      sum_r <= sum_add;
    end
    if (cmd.load_out) begin
      out_data_r <= {3'b000, seen_r, min_r, max_r, level_r, period_r};
      out_user_r <= upd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, slot_r} < CNT_W'(SLOTS)) else $error("slot index past table end");
  a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
    miss_r <= MISS_W'(MISS_LIMIT)) else $error("miss count past limit");
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (min_r <= max_r)) else $error("smallest sample above largest");
  a_period_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sum_step && status.sum_last) |=> upd_r) else $error("new period not flagged");

endmodule

### rtl/core/slope_matched_pitch_detector.sv
// Slope-matched pitch detector for 12-bit microphone samples.
// Input channel in_*: one word per item. in_tuser is the action (0 = new
// sample, 1 = level read that decays the peak level by one), in_tdata[11:0]
// is the sample. Result channel out_*: exactly one word per input word, in
// order; out_tuser flags a freshly measured period.
// Configuration channel cfg_*: index 0 crossing threshold, 1 slope
// tolerance, 2 gap tolerance; cfg_ready is always high. Write only while
// no item is in flight.
// An accepted item is captured and evaluated; when a repeating crossing
// closes a period, the gap sum then adds the logged gaps (1 to SLOTS-1),
// one table entry a cycle, before the result enters the output slot. The
// next item is taken once the result has been loaded into that slot.
// A result waiting for out_tready does not block the next input word; the
// following result waits until the output slot frees up.
// Reset (rst_n low, synchronous) restores the default configuration and
// clears tables, counters, level and statistics; lower starts at 4095.
module slope_matched_pitch_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [smpd_pkg::IN_W-1:0]        in_tdata,   // sample[11:0], zero fill
  input  logic                             in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [smpd_pkg::OUT_W-1:0]       out_tdata,  // period, level, upper, lower, seen
  output logic                             out_tuser,  // period_updated
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smpd_pkg::CFG_A_W-1:0]     cfg_index,
  input  logic [smpd_pkg::GAP_W-1:0]       cfg_data
);
  import smpd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  // sequencer
  smpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // detector datapath and output slot
  smpd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### bench/slope_matched_pitch_detector_tb.sv
module slope_matched_pitch_detector_tb;
  import smpd_pkg::*;

  localparam logic ACT_LEVEL_READ = 1'b1;
  localparam int   SETTLE_CYCLES  = SLOTS + 4;
  localparam int   STALL_LIMIT    = 2000;
  localparam int   PHASE_WORDS    = 190;

  typedef enum logic [1:0] {
    E_WORD,
    E_SETUP,
    E_FLUSH
  } entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic        act;
    logic [11:0] smp;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
  } pending_entry_t;

  typedef struct {
    int period;
    int fresh;
    int level;
    int upper;
    int lower;
    int seen;
  } pitch_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;   // sample[11:0], zero fill
  logic                 in_tuser;   // action
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;  // period, level, upper, lower, seen
  logic                 out_tuser;  // period_updated
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_A_W-1:0]   cfg_index;
  logic [GAP_W-1:0]     cfg_data;

  slope_matched_pitch_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // stimulus and expectation stores
  pending_entry_t pending[$];
  pitch_result_t  expected_results[$];

  // bookkeeping
  int  errors;
  int  words_sent;
  int  reads_sent;
  int  words_checked;
  int  periods_seen;
  int  setups_done;
  int  quiet_cycles;
  int  hold_left;
  int  gen_words;
  int  gen_thr;
  logic in_took;
  logic cfg_took;

  // detector mirror: configuration
  int thr_q;
  int stol_q;
  int gtol_q;

  // detector mirror: state
  int prev_q;
  int tick_q;
  int slope_tab[SLOTS];
  int gap_tab[SLOTS];
  int slot_q;
  int peak_slope_q;
  int misses_q;
  int period_q;
  int level_q;
  int hi_q;
  int lo_q;
  int seen_q;

  function automatic int spread(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic reset_detector();
    thr_q = THR_RESET;
    stol_q = STOL_RESET;
    gtol_q = GTOL_RESET;
    prev_q = 0;
    tick_q = 0;
    foreach (slope_tab[k]) begin
      slope_tab[k] = 0;
      gap_tab[k] = 0;
    end
    slot_q = 0;
    peak_slope_q = 0;
    misses_q = 0;
    period_q = 0;
    level_q = 0;
    hi_q = 0;
    lo_q = SMP_MAX;
    seen_q = 0;
  endtask

  task automatic restart_search();
    slot_q = 0;
    misses_q = 0;
    peak_slope_q = 0;
  endtask

  task automatic apply_setup(input logic [CFG_A_W-1:0] idx, input logic [GAP_W-1:0] val);
    case (idx)
      CFG_THRESHOLD: thr_q = val & 16'h0FFF;
      CFG_SLOPE_TOL: stol_q = val & 16'h0FFF;
      CFG_GAP_TOL:   gtol_q = val;
      default: ;
    endcase
  endtask

  // advance the mirror by one word and report what the block should send
  task automatic step_detector(input logic act, input logic [11:0] smp,
                               output pitch_result_t r);
    int prev;
    int slope;
    int idx;
    int sum;
    int fresh;
    fresh = 0;
    if (act == ACT_SAMPLE) begin
      prev = prev_q;
      prev_q = smp;
      if (smp > hi_q) hi_q = smp;
      if (smp < lo_q) lo_q = smp;
      seen_q = 1;
      if (smp > level_q) level_q = smp;
      else if (level_q > 0) level_q = level_q - 1;
      // upward threshold crossing
      if (prev < thr_q && smp >= thr_q) begin
        slope = (smp - prev) & 12'hFFF;
        if (spread(slope, peak_slope_q) < stol_q) begin
          idx = (slot_q < SLOTS) ? slot_q : 0;
          slope_tab[idx] = slope;
          gap_tab[idx] = tick_q;
          tick_q = 0;
          if (idx == 0) begin
            misses_q = 0;
            slot_q = 1;
          end else if (spread(gap_tab[0], gap_tab[idx]) < gtol_q &&
                       spread(slope_tab[0], slope) < stol_q) begin
            // pattern repeats: gaps since the first entry form the period
            sum = 0;
            for (int k = 0; k < idx; k++) sum = (sum + gap_tab[k]) & 16'hFFFF;
            period_q = sum;
            fresh = 1;
            gap_tab[0] = gap_tab[idx];
            slope_tab[0] = slope_tab[idx];
            slot_q = 1;
            misses_q = 0;
          end else begin
            slot_q = idx + 1;
            if (slot_q > SLOTS - 1) restart_search();
          end
        end else if (slope > peak_slope_q) begin
          peak_slope_q = slope;
          tick_q = 0;
          misses_q = 0;
          slot_q = 0;
        end else begin
          misses_q = misses_q + 1;
          if (misses_q > MISS_LIMIT) restart_search();
        end
      end
      tick_q = (tick_q + 1) & 16'hFFFF;
    end else if (level_q > 0) begin
      level_q = level_q - 1;
    end
    r.period = period_q;
    r.fresh = fresh;
    r.level = level_q;
    r.upper = hi_q;
    r.lower = lo_q;
    r.seen = seen_q;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // stimulus builders
  task automatic queue_word(input logic act, input int smp);
    pending_entry_t e;
    e.kind = E_WORD;
    e.act = act;
    e.smp = smp[11:0];
    e.reg_idx = '0;
    e.reg_val = '0;
    pending.push_back(e);
    gen_words++;
  endtask

  task automatic queue_setup(input logic [CFG_A_W-1:0] idx, input int val);
    pending_entry_t e;
    e.kind = E_SETUP;
    e.act = ACT_SAMPLE;
    e.smp = '0;
    e.reg_idx = idx;
    e.reg_val = val[15:0];
    pending.push_back(e);
    if (idx == CFG_THRESHOLD) gen_thr = val & 12'hFFF;
  endtask

  task automatic queue_flush();
    pending_entry_t e;
    e.kind = E_FLUSH;
    e.act = ACT_SAMPLE;
    e.smp = '0;
    e.reg_idx = '0;
    e.reg_val = '0;
    pending.push_back(e);
  endtask

  // repeating one-slope ramp, one threshold crossing per period unless messy
  task automatic queue_waveform(input int per, input int step, input int base,
                                input int reps, input bit messy);
    int v;
    for (int r = 0; r < reps; r++) begin
      for (int k = 0; k < per; k++) begin
        v = base + k * step;
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
        if (messy && $urandom_range(99) < 3) v = $urandom_range(4095);
        if (messy && $urandom_range(99) < 8) queue_word(ACT_LEVEL_READ, $urandom_range(4095));
        queue_word(ACT_SAMPLE, v);
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one word or register write on the bus at a time
  always @(negedge clk) begin
    logic word_busy;
    logic setup_busy;
    logic calm_in;
    logic calm_out;
    pending_entry_t head;
    word_busy = in_tvalid && !in_took;
    setup_busy = cfg_valid && !cfg_took;
    calm_in = words_sent >= 500 && words_sent < 800;
    calm_out = words_checked >= 500 && words_checked < 800;
    if (rst_n && !word_busy && !setup_busy) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
      end else if (pending.size() != 0) begin
        head = pending[0];
        case (head.kind)
          E_WORD: begin
            if (calm_in || $urandom_range(99) >= 24) begin
              word_busy = 1'b1;
              in_tuser <= head.act;
              in_tdata <= {{(IN_W-SMP_W){1'b0}}, head.smp};
              void'(pending.pop_front());
            end
          end
          E_SETUP: begin
            setup_busy = 1'b1;
            cfg_index <= head.reg_idx;
            cfg_data <= head.reg_val;
            void'(pending.pop_front());
          end
          E_FLUSH: begin
            if (expected_results.size() == 0) begin
              void'(pending.pop_front());
              hold_left = SETTLE_CYCLES;
            end
          end
          default: ;
        endcase
      end
    end
    in_tvalid <= word_busy;
    cfg_valid <= setup_busy;
    out_tready <= calm_out || ($urandom_range(99) >= 24);
  end

  // monitor, predictor hook and stall watchdog
  always @(posedge clk) begin
    pitch_result_t want;
    pitch_result_t got;
    logic moved;
    in_took <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst_n) begin
      moved = 1'b0;
      // result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        words_checked++;
        got.period = out_tdata[15:0];
        got.level = out_tdata[27:16];
        got.upper = out_tdata[39:28];
        got.lower = out_tdata[51:40];
        got.seen = out_tdata[52];
        got.fresh = out_tuser;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none got %h/%b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_results.pop_front();
          if (want.fresh != 0) periods_seen++;
          check_field("period", want.period, got.period);
          check_field("period_updated", want.fresh, got.fresh);
          check_field("level", want.level, got.level);
          check_field("upper", want.upper, got.upper);
          check_field("lower", want.lower, got.lower);
          check_field("seen", want.seen, got.seen);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        apply_setup(cfg_index, cfg_data);
        setups_done++;
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        step_detector(in_tuser, in_tdata[SMP_W-1:0], want);
        expected_results.push_back(want);
        words_sent++;
        if (in_tuser == ACT_LEVEL_READ) reads_sent++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    int phase_start;
    int per;
    int step;
    int k0;
    int base;
    int len;
    int room;
    int reps;
    int thr_pick;
    int stol_pick;
    int gtol_pick;
    bit paused;
    errors = 0;
    words_sent = 0;
    reads_sent = 0;
    words_checked = 0;
    periods_seen = 0;
    setups_done = 0;
    quiet_cycles = 0;
    hold_left = 0;
    gen_words = 0;
    gen_thr = THR_RESET;
    in_took = 1'b0;
    cfg_took = 1'b0;
    paused = 1'b0;
    reset_detector();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_SAMPLE;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;

    // directed: reads before any sample, a clean repeating ramp, field extremes
    queue_word(ACT_LEVEL_READ, 12'hFFF);
    queue_word(ACT_LEVEL_READ, 0);
    queue_waveform(5, 300, 1400, 3, 1'b0);
    queue_word(ACT_LEVEL_READ, 12'h555);
    queue_word(ACT_SAMPLE, 12'hFFF);
    queue_word(ACT_SAMPLE, 0);
    queue_word(ACT_SAMPLE, 12'hAAA);
    queue_word(ACT_SAMPLE, 12'h555);

    // settings phases, extremes first
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin thr_pick = 4095; stol_pick = 4095; gtol_pick = 65535; end
        1: begin thr_pick = 0;    stol_pick = 0;    gtol_pick = 0;     end
        2: begin thr_pick = 1;    stol_pick = 1;    gtol_pick = 1;     end
        3: begin thr_pick = 2200; stol_pick = 6;    gtol_pick = 6;     end
        default: begin
          thr_pick = $urandom_range(3800, 200);
          stol_pick = $urandom_range(40, 1);
          gtol_pick = $urandom_range(20, 0);
        end
      endcase
      queue_flush();
      queue_setup(CFG_THRESHOLD, thr_pick);
      queue_setup(CFG_SLOPE_TOL, stol_pick);
      queue_setup(CFG_GAP_TOL, gtol_pick);
      phase_start = gen_words;
      while (gen_words - phase_start < PHASE_WORDS) begin
        // sender holds off once until the pipeline has emptied
        if (phase == 5 && !paused && gen_words - phase_start > 90) begin
          queue_flush();
          paused = 1'b1;
        end
        // words left in this phase
        room = PHASE_WORDS - (gen_words - phase_start);
        if ($urandom_range(99) < 15) begin
          // noise and broken sequences
          len = $urandom_range(40, 5);
          if (len > room) len = room;
          for (int k = 0; k < len; k++)
            queue_word($urandom_range(99) < 12, $urandom_range(4095));
        end else begin
          per = ($urandom_range(9) == 0) ? $urandom_range(200, 31) : $urandom_range(30, 3);
          if (per > room) per = (room > 3) ? room : 3;
          step = 4095 / per;
          if (step > 600) step = 600;
          step = $urandom_range(step, 1);
          k0 = $urandom_range(per - 1, 1);
          base = gen_thr - k0 * step + $urandom_range(step - 1, 0);
          reps = $urandom_range(8, 3);
          while (reps > 1 && per * reps > room) reps--;
          queue_waveform(per, step, base, reps, 1'b1);
        end
      end
    end

    // reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the stimulus to drain and the results to arrive
    while (pending.size() != 0 || in_tvalid || cfg_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("run covered %0d words (%0d level reads) under %0d register writes,",
             words_sent, reads_sent, setups_done);
    $display("with %0d results checked and %0d fresh periods measured",
             words_checked, periods_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
